FILE: design/woi_pkg.sv
// package for the wheel odometry integrator
// widths, register indexes, cordic constants and the arctangent table; no dependencies
package woi_pkg;
    localparam int SINCOS_ITERATIONS = 16;
    localparam int POSITION_BITS     = 48;
    localparam int CORDIC_STEPS      = (SINCOS_ITERATIONS > 30) ? 30 : SINCOS_ITERATIONS;
    localparam int STEP_W            = 5;
    localparam int CFG_IDX_W         = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 8'd1;

    localparam logic [23:0] DIST_RESET  = 24'd562210;
    localparam logic [23:0] ANGLE_RESET = 24'd497103;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // signed angle shift of pi/4 .. in binary angle units
    function automatic logic signed [33:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10680862;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670675;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                5'd24: v = 34'sd41;
                5'd25: v = 34'sd20;
                5'd26: v = 34'sd10;
                5'd27: v = 34'sd5;
                5'd28: v = 34'sd3;
                5'd29: v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic                     mode;
        logic signed [15:0]       delta_left;
        logic signed [15:0]       delta_right;
        logic [19:0]              interval_us;
    } t_upd;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] turn_rate;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [23:0]          data;
    } t_cfg;

    // divider request/status between sequencer and divider
    typedef struct packed {
        logic               start;
        logic               neg;
        logic [63:0]        num;
        logic [39:0]        den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_sts;
endpackage

FILE: design/woi_if.sv
// valid/ready channel interface carrying one request payload
// no dependencies; the payload type is set by parameter T
interface woi_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/woi_div.sv
// restoring divider, one quotient bit per cycle, saturating to 32 bit signed
// depends on woi_pkg
module woi_div import woi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_sts o_sts
);
    logic [63:0] r_num;
    logic [40:0] r_rem;
    logic [39:0] r_den;
    logic        r_neg;
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [40:0] n_rem;
    logic [40:0] w_trial;
    logic        r_done;
    logic [31:0] w_mag;

    // one shift and trial subtract per cycle
    always_comb begin
        n_rem   = {r_rem[39:0], r_num[63]};
        w_trial = n_rem - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_trial[40]) begin
                r_rem <= w_trial;
                r_num <= {r_num[62:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_num <= {r_num[62:0], 1'b0};
            end
        end
    end

    // saturate magnitude then apply sign
    always_comb begin
        if (r_neg) begin
            w_mag = (r_num[63:31] != '0) ? 32'h8000_0000 : {1'b0, r_num[30:0]};
            o_sts.quot = -$signed(w_mag);
        end else begin
            w_mag = (r_num[63:31] != '0) ? 32'h7fff_ffff : {1'b0, r_num[30:0]};
            o_sts.quot = $signed(w_mag);
        end
        o_sts.done = r_done;
    end
endmodule

FILE: design/wheel_odometry_integrator.sv
// wheel odometry integrator top level: sequencer, cordic datapath, pose state
// depends on woi_pkg, woi_chan_if and woi_div
//
// Usage: updates arrive on i_upd (mode, delta_left, delta_right, interval_us);
// each yields one result on o_res holding the pose and rates after the update.
// Registers are written on i_cfg (index 0 distance_per_count, 1 angle_per_count),
// only while the block is idle with no result waiting; other indexes are ignored.
// A clear request goes straight to S_OUT, which loads the result register.
// An integrate request passes S_PREP for set-up, CORDIC_STEPS rotation steps
// in S_ROT, the position multiply in S_MULX, S_MULXH, S_MULY and S_MULYH on one
// shared 22x32 multiplier, the position update in S_POS, then two divisions
// through the shared divider, skipped when the interval is zero, before S_OUT.
// i_upd.ready is low from acceptance until the sequencer is idle again, and while
// a register write is offered.
// Reset sets registers to their defaults and zeroes pose and rates.
// When the receiver stalls the result holds in the output register; one more
// request may be taken and computed, it then waits in its last state and no
// further request is taken until the output register is free.
module wheel_odometry_integrator import woi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    woi_chan_if.sink   i_cfg,
    woi_chan_if.sink   i_upd,
    woi_chan_if.source o_res
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_ROT   = 4'd2;
    localparam logic [3:0] S_MULX  = 4'd3;
    localparam logic [3:0] S_MULY  = 4'd4;
    localparam logic [3:0] S_POS   = 4'd5;
    localparam logic [3:0] S_DIV1  = 4'd6;
    localparam logic [3:0] S_DIV1W = 4'd7;
    localparam logic [3:0] S_DIV2  = 4'd8;
    localparam logic [3:0] S_DIV2W = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_MULXH = 4'd11;
    localparam logic [3:0] S_MULYH = 4'd12;

    localparam logic signed [63:0] POS_HI = 64'sd0 + ((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
    localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;

    logic [3:0]  r_state;
    logic [23:0] r_dist, r_ang;
    logic        r_out_valid;
    t_res        r_out;

    logic signed [63:0] r_x, r_y;
    logic [31:0] r_head;
    logic signed [31:0] r_speed, r_rate;

    logic signed [41:0] r_travel;
    logic signed [41:0] r_turn;
    logic [19:0] r_iv;
    logic        r_flip;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [STEP_W-1:0] r_step;
    logic signed [63:0] r_dx;
    logic signed [76:0] r_prod;

    t_div_req w_dreq;
    t_div_sts w_dsts;

    logic [31:0] w_mid;
    logic [31:0] w_fold;
    logic signed [16:0] w_l, w_r;
    logic signed [63:0] w_dy;
    logic signed [31:0] w_cos, w_sin;
    logic               w_mul_lo;
    logic signed [21:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [53:0] w_mul_p;
    logic               w_out_load;

    assign i_cfg.ready = (r_state == S_IDLE) && !r_out_valid;
    assign i_upd.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_l = -$signed({i_upd.data.delta_left[15], i_upd.data.delta_left});
    assign w_r = $signed({i_upd.data.delta_right[15], i_upd.data.delta_right});
    assign w_mid  = r_head + 32'(r_turn >>> 1);
    assign w_fold = (w_mid[31] != w_mid[30]) ? (w_mid ^ 32'h8000_0000) : w_mid;

    // shared multiplier: travel split in low and high halves times cos or sin
    assign w_cos    = 32'(r_flip ? -r_cx : r_cx);
    assign w_sin    = 32'(r_flip ? -r_cy : r_cy);
    assign w_mul_lo = (r_state == S_MULX) || (r_state == S_MULY);
    assign w_mul_a  = w_mul_lo ? $signed({1'b0, r_travel[20:0]})
                               : $signed({r_travel[41], r_travel[41:21]});
    assign w_mul_b  = ((r_state == S_MULX) || (r_state == S_MULXH)) ? w_cos : w_sin;
    assign w_mul_p  = 54'(w_mul_a) * 54'(w_mul_b);

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    // saturating position add
    function automatic logic signed [63:0] pos_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] d);
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(d);
            if (s > 65'(POS_HI)) return POS_HI;
            if (s < 65'(POS_LO)) return POS_LO;
            return 64'(s);
        end
    endfunction

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DIST_RESET;
            r_ang  <= ANGLE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.data.index == REG_DISTANCE) r_dist <= i_cfg.data.data;
            else if (i_cfg.data.index == REG_ANGLE) r_ang <= i_cfg.data.data;
        end
    end

    // divider request
    always_comb begin
        w_dreq = '0;
        if (r_state == S_DIV1) begin
            w_dreq.start = 1'b1;
            w_dreq.neg   = r_travel[41];
            w_dreq.num   = 64'(r_travel[41] ? -r_travel : r_travel) * 64'd1000000;
            w_dreq.den   = {3'd0, r_iv, 17'd0};
        end else if (r_state == S_DIV2) begin
            w_dreq.start = 1'b1;
            w_dreq.neg   = r_turn[41];
            w_dreq.num   = 64'(r_turn[41] ? -r_turn : r_turn) * 64'd1000000;
            w_dreq.den   = {4'd0, r_iv, 16'd0};
        end
    end

    woi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_sts(w_dsts));

    assign w_dy = 64'(r_prod >>> 39);

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x <= '0; r_y <= '0; r_head <= '0; r_speed <= '0; r_rate <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_upd.valid && i_upd.ready) begin
                        if (i_upd.data.mode) begin
                            r_x <= '0; r_y <= '0; r_head <= '0;
                            r_speed <= '0; r_rate <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_travel <= 42'(w_l + w_r) * $signed({18'd0, r_dist});
                            r_turn   <= 42'(w_r - w_l) * $signed({18'd0, r_ang});
                            r_iv     <= i_upd.data.interval_us;
                            r_state  <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_flip  <= (w_mid[31] != w_mid[30]);
                    r_cz    <= 34'($signed(w_fold));
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_step  <= '0;
                    r_head  <= r_head + r_turn[31:0];
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - (r_cy >>> r_step);
                        r_cy <= r_cy + (r_cx >>> r_step);
                        r_cz <= r_cz - atan_lut(r_step);
                    end else begin
                        r_cx <= r_cx + (r_cy >>> r_step);
                        r_cy <= r_cy - (r_cx >>> r_step);
                        r_cz <= r_cz + atan_lut(r_step);
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) r_state <= S_MULX;
                end
                S_MULX: begin
                    r_prod  <= 77'(w_mul_p);
                    r_state <= S_MULXH;
                end
                S_MULXH: begin
                    r_prod  <= r_prod + (77'(w_mul_p) <<< 21);
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_dx    <= w_dy;
                    r_prod  <= 77'(w_mul_p);
                    r_state <= S_MULYH;
                end
                S_MULYH: begin
                    r_prod  <= r_prod + (77'(w_mul_p) <<< 21);
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_x <= pos_add(r_x, r_dx);
                    r_y <= pos_add(r_y, w_dy);
                    if (r_iv == '0) begin
                        r_speed <= '0; r_rate <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1:  r_state <= S_DIV1W;
                S_DIV1W: if (w_dsts.done) begin
                    r_speed <= w_dsts.quot;
                    r_state <= S_DIV2;
                end
                S_DIV2:  r_state <= S_DIV2W;
                S_DIV2W: if (w_dsts.done) begin
                    r_rate  <= w_dsts.quot;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.pos_x     <= r_x[47:0];
            r_out.pos_y     <= r_y[47:0];
            r_out.heading   <= r_head;
            r_out.speed     <= r_speed;
            r_out.turn_rate <= r_rate;
        end
    end

    // assertions
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_upd.ready) else $error("ready while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("result dropped");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_res.valid) else $error("result not shown");
endmodule

FILE: sim/tb_wheel_odometry_integrator.sv
// testbench for the wheel odometry integrator: directed and random update requests,
// register writes between phases, result checking against a pose predictor
// depends on woi_pkg, woi_chan_if and the wheel_odometry_integrator rtl
`timescale 1ns / 1ps

module tb_wheel_odometry_integrator;
    import woi_pkg::*;

    // pose predictor and pending results
    class pose_scoreboard;
        logic [23:0]        dist_gain;
        logic [23:0]        angle_gain;
        logic signed [63:0] x_pos;
        logic signed [63:0] y_pos;
        logic [31:0]        heading_now;
        logic signed [31:0] speed_now;
        logic signed [31:0] rate_now;
        t_res               pending[$];
        int                 errors;

        function new();
            dist_gain   = DIST_RESET;
            angle_gain  = ANGLE_RESET;
            x_pos       = 0;
            y_pos       = 0;
            heading_now = 0;
            speed_now   = 0;
            rate_now    = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
            if (idx == REG_DISTANCE) dist_gain = val;
            else if (idx == REG_ANGLE) angle_gain = val;
        endfunction

        // floor division by a power of two
        function automatic logic signed [127:0] fshr(logic signed [127:0] v, int s);
            return v >>> s;
        endfunction

        function automatic logic signed [63:0] clamp32(logic signed [127:0] v);
            if (v > 128'sd2147483647) return 64'sd2147483647;
            if (v < -128'sd2147483648) return -64'sd2147483648;
            return v[63:0];
        endfunction

        function automatic logic signed [63:0] add_pos(logic signed [63:0] acc,
                                                       logic signed [63:0] d);
            logic signed [64:0] s;
            logic signed [64:0] hi;
            hi = (65'sd1 <<< (POSITION_BITS - 1)) - 1;
            s = acc + d;
            if (s > hi) return hi[63:0];
            if (s < -hi - 1) return 64'(-hi - 1);
            return s[63:0];
        endfunction

        // rotate a unit vector to the given binary angle
        function automatic void rotate(logic [31:0] ang, output logic signed [63:0] co,
                                       output logic signed [63:0] si);
            logic               flip;
            logic [31:0]        u;
            logic signed [63:0] z, x, y, xs, ys;
            flip = ang[31] != ang[30];
            u = flip ? (ang ^ 32'h8000_0000) : ang;
            z = $signed(u);
            x = CORDIC_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_lut(i[4:0]);
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_lut(i[4:0]);
                end
            end
            co = flip ? -x : x;
            si = flip ? -y : y;
        endfunction

        function void note_update(t_upd u);
            logic signed [63:0]  lc, rc, trav, turn, co, si;
            logic signed [127:0] p;
            logic [31:0]         mid;
            t_res                r;
            if (u.mode) begin
                x_pos = 0; y_pos = 0; heading_now = 0; speed_now = 0; rate_now = 0;
            end else begin
                lc = -64'(u.delta_left);
                rc = 64'(u.delta_right);
                trav = (lc + rc) * $signed({40'd0, dist_gain});
                turn = (rc - lc) * $signed({40'd0, angle_gain});
                mid = heading_now + 32'(turn >>> 1);
                rotate(mid, co, si);
                p = 128'(trav) * 128'(co);
                x_pos = add_pos(x_pos, 64'(fshr(p, 39)));
                p = 128'(trav) * 128'(si);
                y_pos = add_pos(y_pos, 64'(fshr(p, 39)));
                heading_now = heading_now + turn[31:0];
                if (u.interval_us != 0) begin
                    speed_now = 32'(clamp32((128'(trav) * 1000000) /
                                            ($signed(128'(u.interval_us)) * 131072)));
                    rate_now = 32'(clamp32((128'(turn) * 1000000) /
                                           ($signed(128'(u.interval_us)) * 65536)));
                end else begin
                    speed_now = 0; rate_now = 0;
                end
            end
            r.pos_x = x_pos[47:0];
            r.pos_y = y_pos[47:0];
            r.heading = heading_now;
            r.speed = speed_now;
            r.turn_rate = rate_now;
            pending.push_back(r);
        endfunction

        task check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                report_err("result with no pending update", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.pos_x !== e.pos_x) report_err("pos_x", got.pos_x, e.pos_x);
            if (got.pos_y !== e.pos_y) report_err("pos_y", got.pos_y, e.pos_y);
            if (got.heading !== e.heading) report_err("heading", got.heading, e.heading);
            if (got.speed !== e.speed) report_err("speed", got.speed, e.speed);
            if (got.turn_rate !== e.turn_rate)
                report_err("turn_rate", got.turn_rate, e.turn_rate);
        endtask

        task report_err(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    woi_chan_if #(.T(t_cfg)) cfg_ch ();
    woi_chan_if #(.T(t_upd)) upd_ch ();
    woi_chan_if #(.T(t_res)) res_ch ();

    pose_scoreboard sb;
    bit             no_idle;
    bit             hold_long;
    int             hold_count;

    wheel_odometry_integrator DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_upd  (upd_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off counted here
    initial begin
        int burst;
        res_ch.ready <= 1'b0;
        hold_count = 0;
        burst = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
            if (hold_long && hold_count < 600) begin
                hold_count++;
                res_ch.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                res_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: val};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every pending result, then let the design settle
    task automatic drain();
        int guard;
        guard = 0;
        upd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_update(t_upd u);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            upd_ch.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        upd_ch.valid <= 1'b1;
        upd_ch.data <= u;
        @(posedge i_clk);
        while (!upd_ch.ready) @(posedge i_clk);
        sb.note_update(u);
    endtask

    function automatic t_upd random_update(int span);
        t_upd u;
        u.mode = ($urandom_range(0, 30) == 0);
        case ($urandom_range(0, 3))
            0: begin
                u.delta_left = 16'($urandom);
                u.delta_right = 16'($urandom);
            end
            default: begin
                u.delta_left = 16'($urandom_range(0, 2 * span) - span);
                u.delta_right = 16'($urandom_range(0, 2 * span) - span);
            end
        endcase
        case ($urandom_range(0, 7))
            0: u.interval_us = 0;
            1: u.interval_us = 20'($urandom_range(1, 8));
            2: u.interval_us = 20'hFFFFF;
            default: u.interval_us = 20'($urandom);
        endcase
        return u;
    endfunction

    initial begin
        t_upd u;
        sb = new();
        no_idle = 1'b0;
        hold_long = 1'b0;
        i_rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        upd_ch.valid <= 1'b0;
        upd_ch.data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, clear, zero interval, heading wrap, saturation
        send_update('{1'b0, 16'sd0, 16'sd0, 20'd0});
        send_update('{1'b0, -16'sd1, 16'sd1, 20'd1000});
        send_update('{1'b0, 16'sd1, -16'sd1, 20'd1});
        send_update('{1'b0, 16'sh8000, 16'sh7FFF, 20'hFFFFF});
        send_update('{1'b0, 16'sh7FFF, 16'sh8000, 20'd1});
        send_update('{1'b0, 16'sh8000, 16'sh8000, 20'd0});
        send_update('{1'b0, 16'sh7FFF, 16'sh7FFF, 20'd3});
        send_update('{1'b1, 16'sh7FFF, 16'sh8000, 20'hFFFFF});
        send_update('{1'b0, -16'sd100, 16'sd100, 20'd5000});
        send_update('{1'b0, -16'sd20000, 16'sd0, 20'd2});
        drain();
        write_reg(REG_DISTANCE, 24'hFFFFFF);
        write_reg(REG_ANGLE, 24'hFFFFFF);
        write_reg(8'd2, 24'h123456);
        write_reg(8'hFF, 24'hABCDEF);
        // large travel per update with full gains
        for (int i = 0; i < 12; i++)
            send_update('{1'b0, 16'sh8000, 16'sh7FFF, 20'd1});
        send_update('{1'b0, 16'sh7FFF, 16'sh8000, 20'd0});
        send_update('{1'b0, 16'sh8000, 16'sh8000, 20'd1});
        send_update('{1'b1, 16'sd0, 16'sd0, 20'd0});
        drain();
        write_reg(REG_DISTANCE, 24'd0);
        write_reg(REG_ANGLE, 24'd0);
        send_update('{1'b0, 16'sh8000, 16'sh7FFF, 20'd1});
        send_update('{1'b0, 16'sd5, -16'sd7, 20'd0});

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin write_reg(REG_DISTANCE, DIST_RESET); write_reg(REG_ANGLE, ANGLE_RESET); end
                5: begin write_reg(REG_DISTANCE, 24'hFFFFFF); write_reg(REG_ANGLE, 24'd1); end
                default: begin
                    write_reg(REG_DISTANCE, 24'($urandom));
                    write_reg(REG_ANGLE, 24'($urandom));
                end
            endcase
            if (ph == 2) hold_long = 1'b1;
            if (ph == 5) no_idle = 1'b1;
            for (int i = 0; i < 270; i++) begin
                u = random_update((ph % 2) ? 40 : 2000);
                send_update(u);
                if (i == 100 && ph == 3) begin
                    // sender pause until every result has arrived
                    drain();
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/woi_pkg.sv
design/woi_if.sv
design/woi_div.sv
design/wheel_odometry_integrator.sv
sim/tb_wheel_odometry_integrator.sv
